// ===== sv/signed_rank_exact_distribution_macros.svh =====
// Assertion macros for the signed-rank distribution block.
`ifndef SIGNED_RANK_EXACT_DISTRIBUTION_MACROS_SVH
`define SIGNED_RANK_EXACT_DISTRIBUTION_MACROS_SVH

// Same-cycle implication, clocked on clock, off during reset.
`define SRED_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, off during reset.
`define SRED_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/sred_pkg.sv =====
// Shared widths and field types for the signed-rank distribution block.
package sred_pkg;

   localparam int STAT_W    = 9;
   localparam int PROB_W    = 25;
   localparam int RANK_W    = 5;
   localparam int FRAC_BITS = 24;

   typedef logic [STAT_W-1:0] stat_type;
   typedef logic [PROB_W-1:0] prob_type;
   typedef logic [RANK_W-1:0] rank_type;

endpackage

// ===== sv/signed_rank_exact_distribution.sv =====
// Exact signed-rank null distribution, one statistic value per transfer.
// An accepted transfer runs the ranks in use (n) in ST_RUN, one rank per cycle from a
// table memory, then registers the result in ST_OUT; a repeat after the last value goes
// straight to ST_OUT. Requests stall outside ST_IDLE; a held result delays the next one.
// Reset (synchronous, active high) sets rank count 1 and clears the sequence;
// the table needs no clearing pass, entries are always written before read.
`include "signed_rank_exact_distribution_macros.svh"

module signed_rank_exact_distribution
   import sred_pkg::*;
#(
   parameter int MAX_RANKS = 24
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  logic     req_restart,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output stat_type rsp_statistic,
   output prob_type rsp_cum_probability,
   output logic     rsp_last,
   input  logic     csr_wr_en,
   input  rank_type csr_wr_data
);

   localparam int WIN = MAX_RANKS + 1;
   localparam int AW  = $clog2(WIN);
   localparam int CW  = MAX_RANKS;
   localparam int RCW = MAX_RANKS + 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;

   logic [1:0]     state_ff, state_in;
   rank_type       rank_ff, rank_in;
   stat_type       cur_k_ff, cur_k_in;
   logic [RCW-1:0] running_ff, running_in;
   logic           done_ff, done_in;
   logic [AW-1:0]  slot_ff, slot_in;
   logic [AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0]  rank_idx_ff, rank_idx_in;
   logic [CW-1:0]  acc_ff, acc_in;
   logic           rsp_valid_ff, rsp_valid_in;
   stat_type       rsp_stat_ff, rsp_stat_in;
   prob_type       rsp_prob_ff, rsp_prob_in;
   logic           rsp_last_ff, rsp_last_in;

   logic [CW-1:0]  count_mem_ff [WIN][WIN];
   logic [CW-1:0]  rd_data_ff;

   logic           wr_en;
   logic [AW-1:0]  wr_row, wr_slot, rd_row, rd_slot;
   logic [CW-1:0]  wr_data;

   logic [AW-1:0]  n_used;
   stat_type       top_k;
   stat_type       k_new;
   logic [AW-1:0]  slot_new;
   logic [CW-1:0]  tap, sum;
   logic [RCW+FRAC_BITS-1:0] scaled;

   function automatic logic [AW-1:0] slot_prev(input logic [AW-1:0] s);
      logic [AW-1:0] r;
      r = (s == '0) ? AW'(WIN - 1) : s - AW'(1);
      return r;
   endfunction

   always_comb begin
      if (rank_ff == '0) begin
         n_used = AW'(1);
      end else if (rank_ff > RANK_W'(MAX_RANKS)) begin
         n_used = AW'(MAX_RANKS);
      end else begin
         n_used = AW'(rank_ff);
      end
   end

   assign top_k  = STAT_W'((10'(n_used) * (10'(n_used) + 10'd1)) >> 1);
   assign scaled = {running_ff, FRAC_BITS'(0)} >> n_used;

   assign k_new    = (req_restart || running_ff == '0) ? '0 : cur_k_ff + STAT_W'(1);
   assign slot_new = (k_new == '0) ? '0 :
                     ((slot_ff == AW'(WIN - 1)) ? '0 : slot_ff + AW'(1));

   assign tap = (cur_k_ff >= STAT_W'(rank_idx_ff)) ? rd_data_ff : '0;
   assign sum = acc_ff + tap;

   always_comb begin
      state_in     = state_ff;
      rank_in      = rank_ff;
      cur_k_in     = cur_k_ff;
      running_in   = running_ff;
      done_in      = done_ff;
      slot_in      = slot_ff;
      rd_ptr_in    = rd_ptr_ff;
      rank_idx_in  = rank_idx_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_stat_in  = rsp_stat_ff;
      rsp_prob_in  = rsp_prob_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en        = 1'b0;
      wr_row       = rank_idx_ff;
      wr_slot      = slot_ff;
      wr_data      = sum;
      rd_row       = rank_idx_ff;
      rd_slot      = slot_prev(rd_ptr_ff);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (done_ff && !req_restart) begin
                  state_in = ST_OUT;
               end else begin
                  if (req_restart) begin
                     running_in = '0;
                  end
                  done_in     = 1'b0;
                  cur_k_in    = k_new;
                  slot_in     = slot_new;
                  wr_en       = 1'b1;
                  wr_row      = '0;
                  wr_slot     = slot_new;
                  wr_data     = CW'(k_new == '0);
                  acc_in      = CW'(k_new == '0);
                  rd_row      = '0;
                  rd_slot     = slot_prev(slot_new);
                  rd_ptr_in   = slot_prev(slot_new);
                  rank_idx_in = AW'(1);
                  state_in    = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            wr_en       = 1'b1;
            acc_in      = sum;
            rd_ptr_in   = slot_prev(rd_ptr_ff);
            rank_idx_in = rank_idx_ff + AW'(1);
            if (rank_idx_ff == n_used) begin
               running_in = running_ff + RCW'(sum);
               done_in    = (cur_k_ff >= top_k);
               state_in   = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_stat_in  = cur_k_ff;
               rsp_prob_in  = scaled[PROB_W-1:0];
               rsp_last_in  = done_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         rank_in    = csr_wr_data;
         cur_k_in   = '0;
         running_in = '0;
         done_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rank_ff      <= RANK_W'(1);
         cur_k_ff     <= '0;
         running_ff   <= '0;
         done_ff      <= 1'b0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rank_ff      <= rank_in;
         cur_k_ff     <= cur_k_in;
         running_ff   <= running_in;
         done_ff      <= done_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff   <= rd_ptr_in;
      rank_idx_ff <= rank_idx_in;
      acc_ff      <= acc_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_prob_ff <= rsp_prob_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         count_mem_ff[wr_row][wr_slot] <= wr_data;
      end
      rd_data_ff <= count_mem_ff[rd_row][rd_slot];
   end

   assign req_stall           = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_statistic       = rsp_stat_ff;
   assign rsp_cum_probability = rsp_prob_ff;
   assign rsp_last            = rsp_last_ff;

   `SRED_ASSERT_NOW(a_rank_idx_range, state_ff == ST_RUN,
      rank_idx_ff != '0 && rank_idx_ff <= n_used, "rank index out of range")
   `SRED_ASSERT_NEXT(a_accept_leaves_idle, req_valid && !req_stall,
      state_ff != ST_IDLE, "transfer accepted but sequencer stayed idle")
   `SRED_ASSERT_NOW(a_done_at_top, done_ff,
      cur_k_ff == top_k, "done flag set away from final statistic")
   `SRED_ASSERT_NOW(a_last_is_one, rsp_valid_ff && rsp_last_ff && n_used <= AW'(FRAC_BITS),
      rsp_prob_ff == (PROB_W'(1) << FRAC_BITS), "final probability is not one")

endmodule
